>>> sv/gpio_port_with_interrupt_detect_core_assert.svh
// Assertion macros for the GPIO interrupt port.
`ifndef GPIO_PORT_WITH_INTERRUPT_DETECT_CORE_ASSERT_SVH
`define GPIO_PORT_WITH_INTERRUPT_DETECT_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define GPIOIRQ_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("gpioirq assertion failed");
`define GPIOIRQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gpioirq assertion failed");
`else
`define GPIOIRQ_ASSERT(name, clk, rst_n, prop)
`define GPIOIRQ_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/gpioirq_pkg.sv
`timescale 1ns / 1ps
package gpioirq_pkg;

  parameter int unsigned NumPins  = 32;
  parameter int unsigned HalfPins = 16;
  parameter int unsigned CodeW    = 2;

  typedef logic [NumPins-1:0] pins_t;

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_READ   = 2'd1,
    REQ_WRITE  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    REG_DATA      = 3'd0,
    REG_DIR       = 3'd1,
    REG_PAD       = 3'd2,
    REG_CTRL_LO   = 3'd3,
    REG_CTRL_HI   = 3'd4,
    REG_MASK      = 3'd5,
    REG_STATUS    = 3'd6,
    REG_BOTH_EDGE = 3'd7
  } reg_e;

  typedef enum logic [CodeW-1:0] {
    CTRL_LOW_LEVEL  = 2'd0,
    CTRL_HIGH_LEVEL = 2'd1,
    CTRL_RISE       = 2'd2,
    CTRL_FALL       = 2'd3
  } ctrl_e;

  typedef struct packed {
    logic [1:0] req_type;
    reg_e       reg_index;
  } access_t;

  typedef struct packed {
    pins_t ctrl_lo;
    pins_t ctrl_hi;
    pins_t both_edge;
    pins_t prev_levels;
  } det_cfg_t;

endpackage

>>> sv/gpioirq_req_if.sv
`timescale 1ns / 1ps
interface gpioirq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [2:0]  reg_index;
  logic [31:0] write_data;
  logic [31:0] pad_levels;

  modport source (output valid, req_type, reg_index, write_data, pad_levels, input ready);
  modport sink (input valid, req_type, reg_index, write_data, pad_levels, output ready);
endinterface

>>> sv/gpioirq_rsp_if.sv
`timescale 1ns / 1ps
interface gpioirq_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [31:0] pad_drive;
  logic [31:0] drive_enable;
  logic        irq;

  modport source (output valid, read_data, pad_drive, drive_enable, irq, input ready);
  modport sink (input valid, read_data, pad_drive, drive_enable, irq, output ready);
endinterface

>>> sv/gpio_port_with_interrupt_detect_core.sv
`timescale 1ns / 1ps
// 32-pin GPIO port with per-pin level/edge interrupt detection. Each request
// transfer samples the pads, sets status bits, then does an optional register
// read or write; one response transfer follows for each request. Throughput is
// one transfer per clock while the response is not stalled. Items pass the
// request register, then the response register, with the detect, register
// update and read mux in the single stage between them. A stalled response
// holds the request register, so at most two items are in flight.
`include "gpio_port_with_interrupt_detect_core_assert.svh"
module gpio_port_with_interrupt_detect_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  gpioirq_req_if.sink       req_i,
  gpioirq_rsp_if.source     rsp_o
);

  logic                 in_vld_q;
  gpioirq_pkg::access_t acc_q;
  gpioirq_pkg::pins_t   wdata_q;
  gpioirq_pkg::pins_t   pads_q;
  logic                 adv;

  logic                 out_vld_q;
  gpioirq_pkg::pins_t   rdata_q;
  gpioirq_pkg::pins_t   drive_q;
  gpioirq_pkg::pins_t   oe_q;
  logic                 irq_q;

  gpioirq_pkg::pins_t   rdata_d;
  gpioirq_pkg::pins_t   drive_d;
  gpioirq_pkg::pins_t   oe_d;
  logic                 irq_d;

  assign adv         = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  // Hold the request payload until it advances.
  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      acc_q   <= '{req_type: req_i.req_type,
                   reg_index: gpioirq_pkg::reg_e'(req_i.reg_index)};
      wdata_q <= req_i.write_data;
      pads_q  <= req_i.pad_levels;
    end
  end

  gpioirq_regfile u_regfile (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv),
    .acc_i   (acc_q),
    .wdata_i (wdata_q),
    .pads_i  (pads_q),
    .rdata_o (rdata_d),
    .drive_o (drive_d),
    .oe_o    (oe_d),
    .irq_o   (irq_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      drive_q   <= '0;
      oe_q      <= '0;
      irq_q     <= 1'b0;
    end else begin
      if (adv) begin
        out_vld_q <= 1'b1;
        drive_q   <= drive_d;
        oe_q      <= oe_d;
        irq_q     <= irq_d;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rdata_q <= rdata_d;
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.read_data    = rdata_q;
  assign rsp_o.pad_drive    = drive_q;
  assign rsp_o.drive_enable = oe_q;
  assign rsp_o.irq          = irq_q;

  `GPIOIRQ_ASSERT_NEXT(a_rdata_zero, clk_i, rst_ni, adv && acc_q.req_type != gpioirq_pkg::REQ_READ, rdata_q == '0)
  `GPIOIRQ_ASSERT_NEXT(a_drive_hold, clk_i, rst_ni, adv && !(acc_q.req_type == gpioirq_pkg::REQ_WRITE && acc_q.reg_index == gpioirq_pkg::REG_DATA), drive_q == $past(drive_q))
  `GPIOIRQ_ASSERT_NEXT(a_req_hold, clk_i, rst_ni, in_vld_q && !adv, in_vld_q && $stable(wdata_q) && $stable(pads_q))
  `GPIOIRQ_ASSERT(a_no_ready_when_full, clk_i, rst_ni, (in_vld_q && out_vld_q && !rsp_o.ready) |-> !req_i.ready)

endmodule

>>> sv/gpioirq_detect.sv
`timescale 1ns / 1ps
module gpioirq_detect (
  input  gpioirq_pkg::det_cfg_t cfg_i,
  input  gpioirq_pkg::pins_t    pads_i,
  output gpioirq_pkg::pins_t    hit_o
);

  gpioirq_pkg::pins_t rise;
  gpioirq_pkg::pins_t fall;
  logic [2*gpioirq_pkg::NumPins-1:0] ctrl_all;

  assign rise     = pads_i & ~cfg_i.prev_levels;
  assign fall     = ~pads_i & cfg_i.prev_levels;
  assign ctrl_all = {cfg_i.ctrl_hi, cfg_i.ctrl_lo};

  always_comb begin
    gpioirq_pkg::ctrl_e code;
    code  = gpioirq_pkg::CTRL_LOW_LEVEL;
    hit_o = '0;
    for (int p = 0; p < gpioirq_pkg::NumPins; p++) begin
      code = gpioirq_pkg::ctrl_e'(ctrl_all[gpioirq_pkg::CodeW*p +: gpioirq_pkg::CodeW]);
      if (cfg_i.both_edge[p]) begin
        hit_o[p] = rise[p] | fall[p];
      end else begin
        case (code)
          gpioirq_pkg::CTRL_LOW_LEVEL:  hit_o[p] = ~pads_i[p];
          gpioirq_pkg::CTRL_HIGH_LEVEL: hit_o[p] = pads_i[p];
          gpioirq_pkg::CTRL_RISE:       hit_o[p] = rise[p];
          default:                      hit_o[p] = fall[p];
        endcase
      end
    end
  end

endmodule

>>> sv/gpioirq_regfile.sv
`timescale 1ns / 1ps
module gpioirq_regfile (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  gpioirq_pkg::access_t acc_i,
  input  gpioirq_pkg::pins_t   wdata_i,
  input  gpioirq_pkg::pins_t   pads_i,
  output gpioirq_pkg::pins_t   rdata_o,
  output gpioirq_pkg::pins_t   drive_o,
  output gpioirq_pkg::pins_t   oe_o,
  output logic                 irq_o
);

  gpioirq_pkg::pins_t data_q, data_d;
  gpioirq_pkg::pins_t dir_q, dir_d;
  gpioirq_pkg::pins_t ctrl_lo_q, ctrl_lo_d;
  gpioirq_pkg::pins_t ctrl_hi_q, ctrl_hi_d;
  gpioirq_pkg::pins_t mask_q, mask_d;
  gpioirq_pkg::pins_t status_q, status_d;
  gpioirq_pkg::pins_t both_q, both_d;
  gpioirq_pkg::pins_t prev_q;
  gpioirq_pkg::pins_t hit;
  gpioirq_pkg::pins_t status_hit;
  gpioirq_pkg::det_cfg_t det_cfg;
  logic is_read;
  logic is_write;

  assign det_cfg = '{ctrl_lo: ctrl_lo_q, ctrl_hi: ctrl_hi_q, both_edge: both_q,
                     prev_levels: prev_q};

  gpioirq_detect u_detect (
    .cfg_i  (det_cfg),
    .pads_i (pads_i),
    .hit_o  (hit)
  );

  assign status_hit = status_q | hit;
  assign is_read    = (acc_i.req_type == gpioirq_pkg::REQ_READ);
  assign is_write   = (acc_i.req_type == gpioirq_pkg::REQ_WRITE);

  always_comb begin
    rdata_o = '0;
    if (is_read) begin
      case (acc_i.reg_index)
        gpioirq_pkg::REG_DATA:    rdata_o = (data_q & dir_q) | (pads_i & ~dir_q);
        gpioirq_pkg::REG_DIR:     rdata_o = dir_q;
        gpioirq_pkg::REG_PAD:     rdata_o = pads_i;
        gpioirq_pkg::REG_CTRL_LO: rdata_o = ctrl_lo_q;
        gpioirq_pkg::REG_CTRL_HI: rdata_o = ctrl_hi_q;
        gpioirq_pkg::REG_MASK:    rdata_o = mask_q;
        gpioirq_pkg::REG_STATUS:  rdata_o = status_hit;
        default:                  rdata_o = both_q;
      endcase
    end
  end

  always_comb begin
    data_d    = data_q;
    dir_d     = dir_q;
    ctrl_lo_d = ctrl_lo_q;
    ctrl_hi_d = ctrl_hi_q;
    mask_d    = mask_q;
    status_d  = status_hit;
    both_d    = both_q;
    if (is_write) begin
      case (acc_i.reg_index)
        gpioirq_pkg::REG_DATA:    data_d    = wdata_i;
        gpioirq_pkg::REG_DIR:     dir_d     = wdata_i;
        gpioirq_pkg::REG_PAD:     ;
        gpioirq_pkg::REG_CTRL_LO: ctrl_lo_d = wdata_i;
        gpioirq_pkg::REG_CTRL_HI: ctrl_hi_d = wdata_i;
        gpioirq_pkg::REG_MASK:    mask_d    = wdata_i;
        gpioirq_pkg::REG_STATUS:  status_d  = status_hit & ~wdata_i;
        default:                  both_d    = wdata_i;
      endcase
    end
  end

  assign drive_o = data_d;
  assign oe_o    = dir_d;
  assign irq_o   = |(status_d & mask_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q    <= '0;
      dir_q     <= '0;
      ctrl_lo_q <= '0;
      ctrl_hi_q <= '0;
      mask_q    <= '0;
      status_q  <= '0;
      both_q    <= '0;
      prev_q    <= '0;
    end else if (load_i) begin
      data_q    <= data_d;
      dir_q     <= dir_d;
      ctrl_lo_q <= ctrl_lo_d;
      ctrl_hi_q <= ctrl_hi_d;
      mask_q    <= mask_d;
      status_q  <= status_d;
      both_q    <= both_d;
      prev_q    <= pads_i;
    end
  end

endmodule

>>> tb/sv/gpio_port_with_interrupt_detect_core_tb.sv
`timescale 1ns / 1ps
module gpio_port_with_interrupt_detect_core_tb;

  localparam logic [1:0] REQ_RESERVED = 2'd3;
  localparam int unsigned RandomReqs  = 550;
  localparam int unsigned SteadyLo    = 200;
  localparam int unsigned SteadyHi    = 320;
  localparam int unsigned BackupAt    = 400;
  localparam int unsigned BackupLen   = 60;

  typedef struct packed {
    logic [1:0]         req_type;
    gpioirq_pkg::reg_e  reg_index;
    gpioirq_pkg::pins_t write_data;
    gpioirq_pkg::pins_t pad_levels;
  } gpio_req_t;

  typedef struct packed {
    gpioirq_pkg::pins_t read_data;
    gpioirq_pkg::pins_t pad_drive;
    gpioirq_pkg::pins_t drive_enable;
    logic               irq;
  } gpio_rsp_t;

  logic clk = 1'b0;
  logic rst_n;

  gpioirq_req_if req_if ();
  gpioirq_rsp_if rsp_if ();

  gpio_port_with_interrupt_detect_core dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #5 clk = ~clk;

  gpioirq_pkg::pins_t port_latch, port_dir, port_ctrl_lo, port_ctrl_hi;
  gpioirq_pkg::pins_t port_mask, port_status, port_both_edge, port_prev_pads;
  gpio_req_t pending_reqs[$];
  gpio_rsp_t expected_rsps[$];
  gpio_req_t cur_req;
  gpio_rsp_t want_rsp;
  int        sent_cnt;
  int        rsp_cnt;
  int        errors;
  int        stall_left;
  bit        backup_done;

  function automatic gpioirq_pkg::pins_t pins_hit(gpioirq_pkg::pins_t pads);
    gpioirq_pkg::pins_t rise, fall, hit;
    gpioirq_pkg::ctrl_e code;
    rise = pads & ~port_prev_pads;
    fall = ~pads & port_prev_pads;
    hit  = '0;
    for (int pin = 0; pin < gpioirq_pkg::NumPins; pin++) begin
      if (port_both_edge[pin]) begin
        hit[pin] = rise[pin] | fall[pin];
      end else begin
        code = gpioirq_pkg::ctrl_e'(pin < gpioirq_pkg::HalfPins
                                    ? port_ctrl_lo[2*pin +: 2]
                                    : port_ctrl_hi[2*(pin-gpioirq_pkg::HalfPins) +: 2]);
        case (code)
          gpioirq_pkg::CTRL_LOW_LEVEL:  hit[pin] = ~pads[pin];
          gpioirq_pkg::CTRL_HIGH_LEVEL: hit[pin] = pads[pin];
          gpioirq_pkg::CTRL_RISE:       hit[pin] = rise[pin];
          default:                      hit[pin] = fall[pin];
        endcase
      end
    end
    return hit;
  endfunction

  function automatic gpio_rsp_t gpio_apply(gpio_req_t r);
    gpio_rsp_t o;
    o = '0;
    port_status    = port_status | pins_hit(r.pad_levels);
    port_prev_pads = r.pad_levels;
    if (r.req_type == gpioirq_pkg::REQ_READ) begin
      case (r.reg_index)
        gpioirq_pkg::REG_DATA:
          o.read_data = (port_latch & port_dir) | (r.pad_levels & ~port_dir);
        gpioirq_pkg::REG_DIR:       o.read_data = port_dir;
        gpioirq_pkg::REG_PAD:       o.read_data = r.pad_levels;
        gpioirq_pkg::REG_CTRL_LO:   o.read_data = port_ctrl_lo;
        gpioirq_pkg::REG_CTRL_HI:   o.read_data = port_ctrl_hi;
        gpioirq_pkg::REG_MASK:      o.read_data = port_mask;
        gpioirq_pkg::REG_STATUS:    o.read_data = port_status;
        gpioirq_pkg::REG_BOTH_EDGE: o.read_data = port_both_edge;
      endcase
    end else if (r.req_type == gpioirq_pkg::REQ_WRITE) begin
      case (r.reg_index)
        gpioirq_pkg::REG_DATA:      port_latch = r.write_data;
        gpioirq_pkg::REG_DIR:       port_dir = r.write_data;
        gpioirq_pkg::REG_PAD:       ;
        gpioirq_pkg::REG_CTRL_LO:   port_ctrl_lo = r.write_data;
        gpioirq_pkg::REG_CTRL_HI:   port_ctrl_hi = r.write_data;
        gpioirq_pkg::REG_MASK:      port_mask = r.write_data;
        gpioirq_pkg::REG_STATUS:    port_status = port_status & ~r.write_data;
        gpioirq_pkg::REG_BOTH_EDGE: port_both_edge = r.write_data;
      endcase
    end
    o.pad_drive    = port_latch;
    o.drive_enable = port_dir;
    o.irq          = |(port_status & port_mask);
    return o;
  endfunction

  function automatic bit take_break(int cnt);
    if (cnt >= SteadyLo && cnt < SteadyHi) return 1'b0;
    return $urandom_range(99) < 21;
  endfunction

  task automatic queue_req(logic [1:0] rt, gpioirq_pkg::reg_e ri,
                           gpioirq_pkg::pins_t wd, gpioirq_pkg::pins_t pl);
    gpio_req_t r;
    r.req_type   = rt;
    r.reg_index  = ri;
    r.write_data = wd;
    r.pad_levels = pl;
    pending_reqs.push_back(r);
  endtask

  task automatic check_field(string name, gpioirq_pkg::pins_t want, gpioirq_pkg::pins_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_if.valid      <= 1'b0;
      req_if.req_type   <= '0;
      req_if.reg_index  <= '0;
      req_if.write_data <= '0;
      req_if.pad_levels <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_rsps.push_back(gpio_apply(cur_req));
        sent_cnt++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_reqs.size() > 0 && !take_break(sent_cnt)) begin
          cur_req            = pending_reqs.pop_front();
          req_if.valid      <= 1'b1;
          req_if.req_type   <= cur_req.req_type;
          req_if.reg_index  <= cur_req.reg_index;
          req_if.write_data <= cur_req.write_data;
          req_if.pad_levels <= cur_req.pad_levels;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected transfer, actual read_data %h", $time, rsp_if.read_data);
          errors++;
        end else begin
          want_rsp = expected_rsps.pop_front();
          check_field("read_data", want_rsp.read_data, rsp_if.read_data);
          check_field("pad_drive", want_rsp.pad_drive, rsp_if.pad_drive);
          check_field("drive_enable", want_rsp.drive_enable, rsp_if.drive_enable);
          check_field("irq", gpioirq_pkg::pins_t'(want_rsp.irq),
                      gpioirq_pkg::pins_t'(rsp_if.irq));
        end
        rsp_cnt++;
      end
      if (!backup_done && rsp_cnt == BackupAt) begin
        stall_left  = BackupLen;
        backup_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= !take_break(rsp_cnt);
      end
    end
  end

  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    gpioirq_pkg::pins_t pads;
    gpioirq_pkg::pins_t wdata;
    logic [1:0]         rt;
    int unsigned        sel;
    rst_n = 1'b0;
    {port_latch, port_dir, port_ctrl_lo, port_ctrl_hi} = '0;
    {port_mask, port_status, port_both_edge, port_prev_pads} = '0;
    sent_cnt    = 0;
    rsp_cnt     = 0;
    errors      = 0;
    stall_left  = 0;
    backup_done = 1'b0;

    queue_req(gpioirq_pkg::REQ_SAMPLE, gpioirq_pkg::REG_DATA, '0, '1);
    queue_req(gpioirq_pkg::REQ_READ, gpioirq_pkg::REG_STATUS, '0, '0);
    queue_req(gpioirq_pkg::REQ_WRITE, gpioirq_pkg::REG_MASK, '1, '0);
    queue_req(gpioirq_pkg::REQ_WRITE, gpioirq_pkg::REG_STATUS, '1, '0);
    queue_req(gpioirq_pkg::REQ_READ, gpioirq_pkg::REG_STATUS, '0, '0);
    queue_req(gpioirq_pkg::REQ_WRITE, gpioirq_pkg::REG_CTRL_LO, 32'h5555_5555, '0);
    queue_req(gpioirq_pkg::REQ_WRITE, gpioirq_pkg::REG_CTRL_HI, 32'hAAAA_AAAA, '0);
    queue_req(gpioirq_pkg::REQ_WRITE, gpioirq_pkg::REG_STATUS, '1, '0);
    queue_req(gpioirq_pkg::REQ_READ, gpioirq_pkg::REG_STATUS, '0, '1);
    queue_req(gpioirq_pkg::REQ_WRITE, gpioirq_pkg::REG_CTRL_LO, '1, '1);
    queue_req(gpioirq_pkg::REQ_WRITE, gpioirq_pkg::REG_CTRL_HI, '1, '1);
    queue_req(gpioirq_pkg::REQ_WRITE, gpioirq_pkg::REG_STATUS, '1, '1);
    queue_req(gpioirq_pkg::REQ_READ, gpioirq_pkg::REG_STATUS, '0, '0);
    queue_req(gpioirq_pkg::REQ_WRITE, gpioirq_pkg::REG_BOTH_EDGE, '1, '0);
    queue_req(gpioirq_pkg::REQ_WRITE, gpioirq_pkg::REG_STATUS, '1, 32'h0F0F_F0F0);
    queue_req(gpioirq_pkg::REQ_READ, gpioirq_pkg::REG_STATUS, '0, 32'hFF00_0FF0);
    queue_req(gpioirq_pkg::REQ_WRITE, gpioirq_pkg::REG_DIR, 32'hFFFF_0000, '0);
    queue_req(gpioirq_pkg::REQ_WRITE, gpioirq_pkg::REG_DATA, 32'hA5A5_5A5A, '0);
    queue_req(gpioirq_pkg::REQ_READ, gpioirq_pkg::REG_DATA, '0, 32'h1234_5678);
    queue_req(gpioirq_pkg::REQ_READ, gpioirq_pkg::REG_DIR, '0, '1);
    queue_req(gpioirq_pkg::REQ_WRITE, gpioirq_pkg::REG_PAD, '1, '0);
    queue_req(gpioirq_pkg::REQ_READ, gpioirq_pkg::REG_PAD, '0, 32'hDEAD_BEEF);
    queue_req(gpioirq_pkg::REQ_READ, gpioirq_pkg::REG_CTRL_LO, '0, '0);
    queue_req(gpioirq_pkg::REQ_READ, gpioirq_pkg::REG_CTRL_HI, '0, '0);
    queue_req(gpioirq_pkg::REQ_READ, gpioirq_pkg::REG_MASK, '0, '0);
    queue_req(gpioirq_pkg::REQ_READ, gpioirq_pkg::REG_BOTH_EDGE, '0, '0);
    queue_req(REQ_RESERVED, gpioirq_pkg::REG_STATUS, '1, '1);

    pads = '1;
    for (int i = 0; i < RandomReqs; i++) begin
      sel = $urandom_range(99);
      if (sel < 30)      rt = gpioirq_pkg::REQ_SAMPLE;
      else if (sel < 65) rt = gpioirq_pkg::REQ_READ;
      else if (sel < 95) rt = gpioirq_pkg::REQ_WRITE;
      else               rt = REQ_RESERVED;
      case ($urandom_range(9))
        0:       wdata = '0;
        1:       wdata = '1;
        default: wdata = $urandom;
      endcase
      if ($urandom_range(3) == 0) pads = $urandom;
      else                        pads = pads ^ ($urandom & $urandom & $urandom);
      queue_req(rt, gpioirq_pkg::reg_e'($urandom_range(7)), wdata, pads);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // drain: wait for every request to go out and every response to come back
    do @(negedge clk);
    while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0);
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
